FILE: src/rfoa_pkg.sv
package rfoa_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RECENT_W = 5;
  localparam int unsigned FILL_W = 5;
  localparam int unsigned CMP_W = (CNT_W > RECENT_W) ? CNT_W : RECENT_W;
  localparam int unsigned SUM_W = SAMPLE_W + PTR_W + 1;
  localparam int unsigned ENTRY_W = STAMP_W + SAMPLE_W;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_MATCH = 2'd2,
    KIND_AVG   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [STAMP_W-1:0]         stamp;
    logic signed [SAMPLE_W-1:0] sample;
  } entry_t;

  function automatic ptr_t ring_next(ptr_t p);
    ring_next = (p == ptr_t'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t ring_prev(ptr_t p);
    ring_prev = (p == '0) ? ptr_t'(DEPTH - 1) : ptr_t'(p - 1'b1);
  endfunction

endpackage

FILE: src/rfoa_if.sv
interface rfoa_in_if;
  import rfoa_pkg::*;

  logic                       valid;
  logic                       ready;
  kind_e                      kind;
  logic [STAMP_W-1:0]         stamp_ms;
  logic signed [SAMPLE_W-1:0] sample;
  logic [RECENT_W-1:0]        recent_n;

  modport source (output valid, kind, stamp_ms, sample, recent_n, input ready);
  modport sink (input valid, kind, stamp_ms, sample, recent_n, output ready);
endinterface

interface rfoa_out_if;
  import rfoa_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [STAMP_W-1:0]         out_stamp;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic signed [SAMPLE_W-1:0] mean;
  logic [FILL_W-1:0]          fill;
  logic                       dropped_oldest;

  modport source (output valid, ok, out_stamp, out_sample, mean, fill, dropped_oldest,
                  input ready);
  modport sink (input valid, ok, out_stamp, out_sample, mean, fill, dropped_oldest,
                output ready);
endinterface

FILE: src/ring_fifo_overwrite_average.sv
// Push goes from acceptance straight to the result stage; pop and pop-newest first
// read one RAM entry. Average of n entries: n reads through the single RAM read
// port (n capped at the entries held), then a one-bit-per-cycle divider.
// One transaction is in work at a time; the next is taken once the result is staged.
// rst_ni clears the pointers and the count; the entry RAM is not cleared.
module ring_fifo_overwrite_average (
  input  logic       clk_i,
  input  logic       rst_ni,
  rfoa_in_if.sink    req_i,
  rfoa_out_if.source rsp_o
);
  import rfoa_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_EVAL,
    ST_SUM,
    ST_DSTART,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e                     state_q;
  kind_e                      kind_q;
  logic [STAMP_W-1:0]         stamp_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  ptr_t                       oldest_q;
  ptr_t                       write_q;
  cnt_t                       held_q;
  ptr_t                       rd_addr_q;
  cnt_t                       use_q;
  cnt_t                       left_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic                       res_ok_q;
  logic [STAMP_W-1:0]         res_stamp_q;
  logic signed [SAMPLE_W-1:0] res_sample_q;
  logic signed [SAMPLE_W-1:0] res_mean_q;
  logic                       res_drop_q;
  logic                       out_valid_q;
  logic                       out_ok_q;
  logic [STAMP_W-1:0]         out_stamp_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic signed [SAMPLE_W-1:0] out_mean_q;
  logic [FILL_W-1:0]          out_fill_q;
  logic                       out_drop_q;

  logic                       accept;
  logic                       full;
  cnt_t                       use_n;
  entry_t                     wr_entry;
  logic [ENTRY_W-1:0]         rd_raw;
  entry_t                     rd_entry;
  logic                       div_start;
  logic                       div_done;
  logic [SUM_W-1:0]           div_quo;
  logic [SUM_W-1:0]           sum_mag;
  logic [SUM_W-1:0]           mean_full;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign full        = (held_q == cnt_t'(DEPTH));
  assign use_n       = (CMP_W'(req_i.recent_n) > CMP_W'(held_q)) ? held_q
                                                                 : cnt_t'(req_i.recent_n);

  assign wr_entry.stamp  = req_i.stamp_ms;
  assign wr_entry.sample = req_i.sample;
  assign rd_entry        = entry_t'(rd_raw);

  rfoa_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (accept && (req_i.kind == KIND_PUSH)),
    .waddr_i(write_q),
    .wdata_i(wr_entry),
    .raddr_i(rd_addr_q),
    .rdata_o(rd_raw)
  );

  assign div_start = (state_q == ST_DSTART);
  assign sum_mag   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign mean_full = sum_q[SUM_W-1] ? SUM_W'(-div_quo) : div_quo;

  rfoa_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(sum_mag),
    .divisor_i (use_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= KIND_PUSH;
      stamp_q      <= '0;
      sample_q     <= '0;
      oldest_q     <= '0;
      write_q      <= '0;
      held_q       <= '0;
      rd_addr_q    <= '0;
      use_q        <= '0;
      left_q       <= '0;
      sum_q        <= '0;
      res_ok_q     <= 1'b0;
      res_stamp_q  <= '0;
      res_sample_q <= '0;
      res_mean_q   <= '0;
      res_drop_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_ok_q     <= 1'b0;
      out_stamp_q  <= '0;
      out_sample_q <= '0;
      out_mean_q   <= '0;
      out_fill_q   <= '0;
      out_drop_q   <= 1'b0;
    end else begin
      if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            kind_q       <= req_i.kind;
            stamp_q      <= req_i.stamp_ms;
            sample_q     <= req_i.sample;
            res_ok_q     <= 1'b0;
            res_stamp_q  <= '0;
            res_sample_q <= '0;
            res_mean_q   <= '0;
            res_drop_q   <= 1'b0;
            state_q      <= ST_OUT;
            case (req_i.kind)
              KIND_PUSH: begin
                write_q  <= ring_next(write_q);
                res_ok_q <= 1'b1;
                if (full) begin
                  oldest_q   <= ring_next(oldest_q);
                  res_drop_q <= 1'b1;
                end else begin
                  held_q <= held_q + 1'b1;
                end
              end
              KIND_POP: begin
                if (held_q != '0) begin
                  rd_addr_q <= oldest_q;
                  state_q   <= ST_LOOK;
                end
              end
              KIND_MATCH: begin
                if (held_q != '0) begin
                  rd_addr_q <= ring_prev(write_q);
                  state_q   <= ST_LOOK;
                end
              end
              default: begin
                if (use_n != '0) begin
                  rd_addr_q <= ring_prev(write_q);
                  use_q     <= use_n;
                  left_q    <= use_n;
                  sum_q     <= '0;
                  state_q   <= ST_LOOK;
                end
              end
            endcase
          end
        end
        ST_LOOK: begin
          if (kind_q == KIND_AVG) begin
            rd_addr_q <= ring_prev(rd_addr_q);
            state_q   <= ST_SUM;
          end else begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (kind_q == KIND_POP) begin
            res_ok_q     <= 1'b1;
            res_stamp_q  <= rd_entry.stamp;
            res_sample_q <= rd_entry.sample;
            oldest_q     <= ring_next(oldest_q);
            held_q       <= held_q - 1'b1;
          end else if (rd_entry.stamp == stamp_q && rd_entry.sample == sample_q) begin
            res_ok_q <= 1'b1;
            write_q  <= ring_prev(write_q);
            held_q   <= held_q - 1'b1;
          end
          state_q <= ST_OUT;
        end
        ST_SUM: begin
          sum_q     <= sum_q + {{(SUM_W-SAMPLE_W){rd_entry.sample[SAMPLE_W-1]}},
                                rd_entry.sample};
          rd_addr_q <= ring_prev(rd_addr_q);
          left_q    <= left_q - 1'b1;
          if (left_q == cnt_t'(1)) begin
            state_q <= ST_DSTART;
          end
        end
        ST_DSTART: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            res_ok_q   <= 1'b1;
            res_mean_q <= mean_full[SAMPLE_W-1:0];
            state_q    <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || rsp_o.ready) begin
            out_valid_q  <= 1'b1;
            out_ok_q     <= res_ok_q;
            out_stamp_q  <= res_stamp_q;
            out_sample_q <= res_sample_q;
            out_mean_q   <= res_mean_q;
            out_fill_q   <= FILL_W'(held_q);
            out_drop_q   <= res_drop_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.ok             = out_ok_q;
  assign rsp_o.out_stamp      = out_stamp_q;
  assign rsp_o.out_sample     = out_sample_q;
  assign rsp_o.mean           = out_mean_q;
  assign rsp_o.fill           = out_fill_q;
  assign rsp_o.dropped_oldest = out_drop_q;

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= cnt_t'(DEPTH)) else $error("entry count above depth");
  a_ptr_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q == '0 || full) |-> oldest_q == write_q)
    else $error("pointers disagree with entry count");
  a_sum_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (left_q != '0 && use_q <= held_q))
    else $error("averaging walk out of range");
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV) else $error("divider result outside wait");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.kind == KIND_PUSH && !full) |=> held_q == $past(held_q) + 1'b1)
    else $error("push did not grow store");

endmodule

FILE: src/rfoa_ram.sv
module rfoa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/rfoa_div.sv
module rfoa_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rfoa_pkg::SUM_W-1:0] dividend_i,
  input  rfoa_pkg::cnt_t            divisor_i,
  output logic                      done_o,
  output logic [rfoa_pkg::SUM_W-1:0] quotient_o
);
  import rfoa_pkg::*;

  localparam int unsigned STEP_W = $clog2(SUM_W + 1);

  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;
  cnt_t              rem_q;
  cnt_t              div_q;
  logic [SUM_W-1:0]  quo_q;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign fits  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rem_q  <= '0;
      div_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        step_q <= STEP_W'(SUM_W);
        busy_q <= 1'b1;
        rem_q  <= '0;
        div_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q  <= fits ? CNT_W'(trial - {1'b0, div_q}) : CNT_W'(trial);
        quo_q  <= {quo_q[SUM_W-2:0], fits};
        step_q <= step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < div_q) else $error("remainder not below divisor");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> divisor_i != '0) else $error("zero divisor");

endmodule

FILE: dv/ring_fifo_overwrite_average_tb.sv
`timescale 1ns / 100ps

module ring_fifo_overwrite_average_tb;
  import rfoa_pkg::*;

  localparam int unsigned RAND_ITEMS  = 1620;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_WAIT  = 64;

  typedef struct packed {
    logic                       ok;
    logic [STAMP_W-1:0]         stamp;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] mean;
    logic [FILL_W-1:0]          fill;
    logic                       dropped;
  } reading_rsp_t;

  typedef struct {
    kind_e                      kind;
    logic [STAMP_W-1:0]         stamp;
    logic signed [SAMPLE_W-1:0] sample;
    logic [RECENT_W-1:0]        recent_n;
    int unsigned                reps;
    bit                         typed;
    reading_rsp_t               want;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;
  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_e;

  localparam reading_rsp_t NO_RSP = '0;

  logic clk;
  logic rst_n;

  rfoa_in_if  req ();
  rfoa_out_if rsp ();

  ring_fifo_overwrite_average i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  // Shadow of the ring contents and pointers
  entry_t      shadow_mem [DEPTH];
  ptr_t        oldest_idx;
  ptr_t        write_idx;
  int unsigned held_cnt;

  reading_rsp_t expected_readings [$];

  int unsigned cycle_cnt;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned overwrites;
  int unsigned averages_used;
  int unsigned match_hits;
  int unsigned burst_left;

  rx_mode_e    rx_mode;
  int unsigned rx_left;

  always #1 clk = ~clk;

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    req.valid    = 1'b0;
    req.kind     = KIND_PUSH;
    req.stamp_ms = '0;
    req.sample   = '0;
    req.recent_n = '0;
    rsp.ready    = 1'b1;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  function automatic ptr_t step_back(ptr_t p);
    return (p == '0) ? ptr_t'(DEPTH - 1) : ptr_t'(p - 1'b1);
  endfunction

  function automatic reading_rsp_t predict_reading(kind_e k, logic [STAMP_W-1:0] st,
                                                   logic signed [SAMPLE_W-1:0] sa,
                                                   logic [RECENT_W-1:0] n);
    reading_rsp_t r;
    ptr_t         idx;
    int           sum;
    int           span;
    r = NO_RSP;
    case (k)
      KIND_PUSH: begin
        shadow_mem[write_idx].stamp  = st;
        shadow_mem[write_idx].sample = sa;
        write_idx = (write_idx == ptr_t'(DEPTH - 1)) ? '0 : ptr_t'(write_idx + 1'b1);
        if (held_cnt >= DEPTH) begin
          oldest_idx = (oldest_idx == ptr_t'(DEPTH - 1)) ? '0 : ptr_t'(oldest_idx + 1'b1);
          r.dropped  = 1'b1;
          overwrites++;
        end else begin
          held_cnt++;
        end
        r.ok = 1'b1;
      end
      KIND_POP: begin
        if (held_cnt != 0) begin
          r.stamp    = shadow_mem[oldest_idx].stamp;
          r.sample   = shadow_mem[oldest_idx].sample;
          oldest_idx = (oldest_idx == ptr_t'(DEPTH - 1)) ? '0 : ptr_t'(oldest_idx + 1'b1);
          held_cnt--;
          r.ok = 1'b1;
        end
      end
      KIND_MATCH: begin
        idx = step_back(write_idx);
        if (held_cnt != 0 && shadow_mem[idx].stamp == st && shadow_mem[idx].sample == sa) begin
          write_idx = idx;
          held_cnt--;
          r.ok = 1'b1;
          match_hits++;
        end
      end
      default: begin
        span = (int'(n) > int'(held_cnt)) ? int'(held_cnt) : int'(n);
        if (span != 0) begin
          sum = 0;
          idx = write_idx;
          for (int j = 0; j < span; j++) begin
            idx = step_back(idx);
            sum += int'(shadow_mem[idx].sample);
          end
          r.mean = SAMPLE_W'(sum / span);
          r.ok   = 1'b1;
          averages_used++;
        end
      end
    endcase
    r.fill = FILL_W'(held_cnt);
    return r;
  endfunction

  task automatic send_reading(input kind_e k, input logic [STAMP_W-1:0] st,
                              input logic signed [SAMPLE_W-1:0] sa,
                              input logic [RECENT_W-1:0] n, input bit typed,
                              input reading_rsp_t want);
    reading_rsp_t model;
    req.valid    <= 1'b1;
    req.kind     <= k;
    req.stamp_ms <= st;
    req.sample   <= sa;
    req.recent_n <= n;
    do @(posedge clk); while (!req.ready);
    model = predict_reading(k, st, sa, n);
    expected_readings.push_back(typed ? want : model);
    items_sent++;
  endtask

  // Drop valid for a gap between bursts; now and then wait for the ring to go quiet
  task automatic pace_sender(input int unsigned idx);
    int unsigned gap;
    gap = 0;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      gap        = $urandom_range(1, 9);
    end
    if (idx % 300 == 150) begin
      req.valid <= 1'b0;
      do @(posedge clk); while (expected_readings.size() != 0);
    end else if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : rsp_check
    reading_rsp_t want;
    if (rst_n && rsp.valid && rsp.ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t ns: unexpected transaction, expected none actual fill %0d", $time,
                 rsp.fill);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        check_field("ok", want.ok, rsp.ok);
        check_field("out_stamp", want.stamp, rsp.out_stamp);
        check_field("out_sample", 32'(want.sample), 32'(rsp.out_sample));
        check_field("mean", 32'(want.mean), 32'(rsp.mean));
        check_field("fill", want.fill, rsp.fill);
        check_field("dropped_oldest", want.dropped, rsp.dropped_oldest);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rx_left != 0) begin
      rx_left <= rx_left - 1;
    end else begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(50, 300);
    end
    case (rx_mode)
      RX_OPEN:   rsp.ready <= 1'b1;
      RX_COIN:   rsp.ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: rsp.ready <= ($urandom_range(0, 7) == 0);
      default:   rsp.ready <= (cycle_cnt % 5 != 0);
    endcase
  end

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t ns: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    stim_row_t                  directed_rows [$];
    stim_row_t                  row;
    op_mix_e                    mix;
    kind_e                      k;
    logic [STAMP_W-1:0]         st;
    logic signed [SAMPLE_W-1:0] sa;
    logic [RECENT_W-1:0]        n;
    int unsigned                roll;
    int unsigned                push_pct;
    int unsigned                pop_pct;
    int unsigned                flip;
    int unsigned                directed_cnt;
    entry_t                     newest;

    oldest_idx = '0;
    write_idx  = '0;
    held_cnt   = 0;
    rx_mode    = RX_OPEN;
    mix        = MIX_EVEN;
    foreach (shadow_mem[i]) shadow_mem[i] = '0;

    // Empty-store corners, extremes, rejected and accepted matches
    directed_rows.push_back('{KIND_POP, '0, '0, 5'd0, 1, 1'b1, NO_RSP});
    directed_rows.push_back('{KIND_MATCH, '0, '0, 5'd0, 1, 1'b1, NO_RSP});
    directed_rows.push_back('{KIND_AVG, '0, '0, 5'd31, 1, 1'b1, NO_RSP});
    directed_rows.push_back('{KIND_PUSH, 32'hFFFF_FFFF, 16'sh8000, 5'd0, 1, 1'b1,
                              '{1'b1, '0, '0, '0, 5'd1, 1'b0}});
    directed_rows.push_back('{KIND_POP, '0, '0, 5'd0, 1, 1'b1,
                              '{1'b1, 32'hFFFF_FFFF, 16'sh8000, '0, 5'd0, 1'b0}});
    directed_rows.push_back('{KIND_PUSH, '0, 16'sh7FFF, 5'd16, 1, 1'b1,
                              '{1'b1, '0, '0, '0, 5'd1, 1'b0}});
    directed_rows.push_back('{KIND_AVG, '0, '0, 5'd0, 1, 1'b1,
                              '{1'b0, '0, '0, '0, 5'd1, 1'b0}});
    directed_rows.push_back('{KIND_AVG, '0, '0, 5'd31, 1, 1'b1,
                              '{1'b1, '0, '0, 16'sh7FFF, 5'd1, 1'b0}});
    directed_rows.push_back('{KIND_MATCH, '0, 16'sh7FFE, 5'd0, 1, 1'b1,
                              '{1'b0, '0, '0, '0, 5'd1, 1'b0}});
    directed_rows.push_back('{KIND_MATCH, 32'd1, 16'sh7FFF, 5'd0, 1, 1'b1,
                              '{1'b0, '0, '0, '0, 5'd1, 1'b0}});
    directed_rows.push_back('{KIND_MATCH, '0, 16'sh7FFF, 5'd0, 1, 1'b1,
                              '{1'b1, '0, '0, '0, 5'd0, 1'b0}});
    // Fill past capacity so the last push overwrites the oldest
    directed_rows.push_back('{KIND_PUSH, 32'h100, 16'sh8000, 5'd0, 17, 1'b0, NO_RSP});
    directed_rows.push_back('{KIND_AVG, '0, '0, 5'd16, 1, 1'b1,
                              '{1'b1, '0, '0, 16'sh8000, 5'd16, 1'b0}});
    directed_rows.push_back('{KIND_POP, '0, '0, 5'd0, 1, 1'b0, NO_RSP});
    directed_rows.push_back('{KIND_PUSH, 32'h7FFF_0000, -16'sd1, 5'd0, 1, 1'b0, NO_RSP});
    directed_rows.push_back('{KIND_PUSH, 32'h8000_0001, -16'sd4, 5'd0, 1, 1'b0, NO_RSP});
    directed_rows.push_back('{KIND_AVG, '0, '0, 5'd2, 1, 1'b0, NO_RSP});
    directed_rows.push_back('{KIND_AVG, '0, '0, 5'd5, 1, 1'b0, NO_RSP});
    directed_rows.push_back('{KIND_MATCH, 32'h8000_0001, -16'sd3, 5'd0, 1, 1'b0, NO_RSP});
    directed_rows.push_back('{KIND_MATCH, 32'h8000_0001, -16'sd4, 5'd0, 1, 1'b0, NO_RSP});
    // Drain to empty and pop once more
    directed_rows.push_back('{KIND_POP, '0, '0, 5'd0, 16, 1'b0, NO_RSP});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    burst_left = 0;
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (int unsigned j = 0; j < row.reps; j++) begin
        send_reading(row.kind, row.stamp + j, row.sample, row.recent_n, row.typed, row.want);
        pace_sender(items_sent);
      end
    end
    directed_cnt = items_sent;

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 64 == 0) mix = op_mix_e'($urandom_range(0, 2));
      push_pct = (mix == MIX_FILL) ? 60 : (mix == MIX_DRAIN) ? 20 : 40;
      pop_pct  = (mix == MIX_DRAIN) ? 45 : 20;
      roll     = $urandom_range(0, 99);
      st       = $urandom();
      case ($urandom_range(0, 9))
        0:       sa = 16'sh8000;
        1:       sa = 16'sh7FFF;
        2:       sa = -16'sd1;
        3:       sa = '0;
        default: sa = SAMPLE_W'($urandom());
      endcase
      n = ($urandom_range(0, 6) == 0) ? RECENT_W'($urandom_range(17, 31))
                                      : RECENT_W'($urandom_range(0, 16));
      if (roll < push_pct) begin
        k = KIND_PUSH;
      end else if (roll < push_pct + pop_pct) begin
        k = KIND_POP;
      end else if (roll < push_pct + pop_pct + 15) begin
        k      = KIND_MATCH;
        newest = shadow_mem[step_back(write_idx)];
        roll   = $urandom_range(0, 9);
        if (held_cnt != 0 && roll < 9) begin
          st = newest.stamp;
          sa = newest.sample;
          // Corrupt a single bit of a real match
          if (roll >= 6) begin
            flip = $urandom_range(0, STAMP_W + SAMPLE_W - 1);
            if (flip < STAMP_W) st[flip] = ~st[flip];
            else sa[flip - STAMP_W] = ~sa[flip - STAMP_W];
          end
        end
      end else begin
        k = KIND_AVG;
      end
      send_reading(k, st, sa, n, 1'b0, NO_RSP);
      pace_sender(items_sent);
    end

    req.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d transactions (%0d directed), checked %0d results", items_sent,
             directed_cnt, results_checked);
    $display("Saw %0d overwrites of the oldest reading, %0d averages, %0d pop-newest hits",
             overwrites, averages_used, match_hits);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
